/* src/lnei_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, word types and a helper function of the lattice neighbour block.
package lnei_pkg;

   localparam int MaxSide     = 64;
   localparam int VIDX_W      = 19;
   localparam int EDGE_W      = 21;
   localparam int DIR_W       = 2;
   localparam int SIDE_W      = 7;
   localparam int COORD_W     = 6;
   localparam int SQ_W        = 13;
   localparam int CUBE_W      = 19;
   localparam int RANGE_W     = CUBE_W + 1;
   localparam int REST_W      = 18;
   localparam int Q1_W        = 12;
   localparam int Q2_W        = 7;
   localparam int R_W         = 8;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int REM_W       = 7;
   localparam int DIV_STEPS   = RECIP_SHIFT + 1;
   localparam int DIV_CNT_W   = 5;

   localparam int ResetSideInt = 4;
   localparam logic [SIDE_W-1:0]  RESET_SIDE  = SIDE_W'(ResetSideInt);
   localparam logic [SQ_W-1:0]    RESET_SQ    = SQ_W'(ResetSideInt * ResetSideInt);
   localparam logic [CUBE_W-1:0]  RESET_CUBE  =
      CUBE_W'(ResetSideInt * ResetSideInt * ResetSideInt);
   localparam logic [RECIP_W-1:0] RESET_RECIP = RECIP_W'((1 << RECIP_SHIFT) / ResetSideInt);
   localparam logic [SIDE_W-1:0]  MAX_SIDE_V  = SIDE_W'(MaxSide);

   localparam logic [DIR_W-1:0] DIR_XY  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_XZ  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_YZ  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_XYZ = 2'd3;

   typedef struct packed {
      logic [VIDX_W-1:0] vertex_index;
      logic [DIR_W-1:0]  direction;
      logic              negative;
   } req_type;

   typedef struct packed {
      logic [VIDX_W-1:0] neighbour_index;
      logic [EDGE_W-1:0] edge_number;
      logic              index_error;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side;
      logic [SQ_W-1:0]    sq;
      logic [CUBE_W-1:0]  cube;
      logic [RECIP_W-1:0] recip;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              err;
      logic              w;
      logic [VIDX_W-1:0] vidx;
      logic [DIR_W-1:0]  dir;
      logic              neg;
   } band_type;

   typedef struct packed {
      band_type                  band;
      logic [2:0][COORD_W-1:0]   crd;
   } coord_type;

   function automatic logic [2:0] paired_of(input logic [DIR_W-1:0] dir);
      logic [2:0] axes;
      case (dir)
         DIR_XY:  axes = 3'b011;
         DIR_XZ:  axes = 3'b101;
         DIR_YZ:  axes = 3'b110;
         DIR_XYZ: axes = 3'b111;
         default: axes = 3'b111;
      endcase
      return axes;
   endfunction

endpackage

/* src/lattice_neighbour_edge_index.sv */
`timescale 1ns / 1ps
// Neighbour and edge index generator for a periodic two-sublattice 3D lattice.
// Throughput: one word per cycle while busy is low, through the ten-stage divide and re-encode pipeline.
// The receiver cannot stall, so every result word is strobed for exactly one cycle.
// After a side length write, busy stays high while the reciprocal divider runs.
// Reset restores side 4 with its derived values at once and empties the pipeline.
module lattice_neighbour_edge_index (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lnei_pkg::req_type           req_word,
   output logic                        rsp_strobe,
   output lnei_pkg::rsp_type           rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lnei_pkg::SIDE_W-1:0] csr_data
);

   lnei_pkg::cfg_type   cfg;
   lnei_pkg::coord_type coord;
   logic                accept;

   assign accept = start & ~busy;

   lnei_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .busy      (busy),
      .cfg       (cfg)
   );

   lnei_split u_split (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .cfg      (cfg),
      .coord    (coord)
   );

   lnei_step u_step (
      .clock      (clock),
      .reset      (reset),
      .coord      (coord),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

/* src/lnei_cfg.sv */
`timescale 1ns / 1ps
// Side length register with derived square, cube and reciprocal of the side.
module lnei_cfg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lnei_pkg::SIDE_W-1:0] csr_data,
   output logic                        busy,
   output lnei_pkg::cfg_type           cfg
);

   logic [lnei_pkg::SIDE_W-1:0]    side_ff, side_in;
   logic [lnei_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic [lnei_pkg::CUBE_W-1:0]    cube_ff, cube_in;
   logic [lnei_pkg::RECIP_W-1:0]   recip_ff, recip_in;
   logic [lnei_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [lnei_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [lnei_pkg::REM_W-1:0]     trial;
   logic                           num_bit;
   logic                           fits;
   logic                           write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      if (csr_data == '0) begin
         side_in = lnei_pkg::SIDE_W'(1);
      end else if (csr_data > lnei_pkg::MAX_SIDE_V) begin
         side_in = lnei_pkg::MAX_SIDE_V;
      end else begin
         side_in = csr_data;
      end
   end

   assign sq_in   = lnei_pkg::SQ_W'(side_ff * side_ff);
   assign cube_in = lnei_pkg::CUBE_W'(sq_ff * side_ff);

   // Restoring division of a power of two by the side, one quotient bit a cycle.
   assign num_bit  = (cnt_ff == lnei_pkg::DIV_CNT_W'(lnei_pkg::DIV_STEPS));
   assign trial    = {rem_ff[lnei_pkg::REM_W-2:0], num_bit};
   assign fits     = (trial >= side_ff);
   assign rem_in   = fits ? (trial - side_ff) : trial;
   assign recip_in = {recip_ff[lnei_pkg::RECIP_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= lnei_pkg::RESET_SIDE;
         sq_ff    <= lnei_pkg::RESET_SQ;
         cube_ff  <= lnei_pkg::RESET_CUBE;
         recip_ff <= lnei_pkg::RESET_RECIP;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         sq_ff   <= sq_in;
         cube_ff <= cube_in;
         if (write) begin
            side_ff  <= side_in;
            recip_ff <= '0;
            rem_ff   <= '0;
            cnt_ff   <= lnei_pkg::DIV_CNT_W'(lnei_pkg::DIV_STEPS);
         end else if (cnt_ff != '0) begin
            recip_ff <= recip_in;
            rem_ff   <= rem_in;
            cnt_ff   <= cnt_ff - 1'b1;
         end
      end
   end

   assign busy      = (cnt_ff != '0);
   assign cfg.side  = side_ff;
   assign cfg.sq    = sq_ff;
   assign cfg.cube  = cube_ff;
   assign cfg.recip = recip_ff;

endmodule

/* src/lnei_split.sv */
`timescale 1ns / 1ps
// Pipeline that splits a vertex index into sublattice and x, y, z coordinates.
module lnei_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lnei_pkg::req_type   req_word,
   input  lnei_pkg::cfg_type   cfg,
   output lnei_pkg::coord_type coord
);

   localparam int P1_W = lnei_pkg::REST_W + lnei_pkg::RECIP_W;
   localparam int P2_W = lnei_pkg::Q1_W + lnei_pkg::RECIP_W;

   lnei_pkg::band_type a_band_ff, a_band_in;
   lnei_pkg::band_type b_band_ff, c_band_ff, d_band_ff, e_band_ff, f_band_ff;
   lnei_pkg::coord_type coord_ff, coord_in;

   logic [lnei_pkg::REST_W-1:0]   a_rest_ff, a_rest_in;
   logic [lnei_pkg::REST_W-1:0]   b_rest_ff, b_q1_ff, b_q1_in;
   logic [lnei_pkg::REST_W-1:0]   c_q1_ff;
   logic [lnei_pkg::R_W-1:0]      c_r1_ff, c_r1_in;
   logic [lnei_pkg::COORD_W-1:0]  d_x_ff, d_x_in, e_x_ff, f_x_ff;
   logic [lnei_pkg::Q1_W-1:0]     d_q1_ff, d_q1_in, e_q1_ff;
   logic [lnei_pkg::Q2_W-1:0]     e_q2_ff, e_q2_in, f_q2_ff;
   logic [lnei_pkg::R_W-1:0]      f_r2_ff, f_r2_in;

   logic [lnei_pkg::RANGE_W-1:0]  twice_cube;
   logic [lnei_pkg::VIDX_W-1:0]   less_cube;
   logic [P1_W-1:0]               prod1;
   logic [lnei_pkg::REST_W-1:0]   back1;
   logic                          fix1;
   logic [P2_W-1:0]               prod2;
   logic [lnei_pkg::Q1_W-1:0]     back2;
   logic                          fix2;

   always_comb begin
      twice_cube      = {cfg.cube, 1'b0};
      less_cube       = req_word.vertex_index - cfg.cube;
      a_band_in.valid = accept;
      a_band_in.err   = ({1'b0, req_word.vertex_index} >= twice_cube);
      a_band_in.w     = (req_word.vertex_index >= cfg.cube);
      a_band_in.vidx  = req_word.vertex_index;
      a_band_in.dir   = req_word.direction;
      a_band_in.neg   = req_word.negative;
      a_rest_in       = a_band_in.w ? lnei_pkg::REST_W'(less_cube)
                                    : lnei_pkg::REST_W'(req_word.vertex_index);
   end

   always_comb begin
      prod1   = P1_W'(a_rest_ff) * P1_W'(cfg.recip);
      b_q1_in = prod1[lnei_pkg::RECIP_SHIFT +: lnei_pkg::REST_W];
   end

   always_comb begin
      back1   = lnei_pkg::REST_W'(b_q1_ff * cfg.side);
      c_r1_in = lnei_pkg::R_W'(b_rest_ff - back1);
   end

   always_comb begin
      fix1    = (c_r1_ff >= lnei_pkg::R_W'(cfg.side));
      d_x_in  = lnei_pkg::COORD_W'(fix1 ? (c_r1_ff - lnei_pkg::R_W'(cfg.side)) : c_r1_ff);
      d_q1_in = lnei_pkg::Q1_W'(c_q1_ff + lnei_pkg::REST_W'(fix1));
   end

   always_comb begin
      prod2   = P2_W'(d_q1_ff) * P2_W'(cfg.recip);
      e_q2_in = prod2[lnei_pkg::RECIP_SHIFT +: lnei_pkg::Q2_W];
   end

   always_comb begin
      back2   = lnei_pkg::Q1_W'(e_q2_ff * cfg.side);
      f_r2_in = lnei_pkg::R_W'(e_q1_ff - back2);
   end

   always_comb begin
      fix2            = (f_r2_ff >= lnei_pkg::R_W'(cfg.side));
      coord_in.band   = f_band_ff;
      coord_in.crd[0] = f_x_ff;
      coord_in.crd[1] = lnei_pkg::COORD_W'(fix2 ? (f_r2_ff - lnei_pkg::R_W'(cfg.side))
                                                : f_r2_ff);
      coord_in.crd[2] = lnei_pkg::COORD_W'(f_q2_ff + lnei_pkg::Q2_W'(fix2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_band_ff <= '0;
         b_band_ff <= '0;
         c_band_ff <= '0;
         d_band_ff <= '0;
         e_band_ff <= '0;
         f_band_ff <= '0;
         coord_ff  <= '0;
      end else begin
         a_band_ff <= a_band_in;
         b_band_ff <= a_band_ff;
         c_band_ff <= b_band_ff;
         d_band_ff <= c_band_ff;
         e_band_ff <= d_band_ff;
         f_band_ff <= e_band_ff;
         coord_ff  <= coord_in;
      end
   end

   always_ff @(posedge clock) begin
      a_rest_ff <= a_rest_in;
      b_rest_ff <= a_rest_ff;
      b_q1_ff   <= b_q1_in;
      c_q1_ff   <= b_q1_ff;
      c_r1_ff   <= c_r1_in;
      d_x_ff    <= d_x_in;
      d_q1_ff   <= d_q1_in;
      e_x_ff    <= d_x_ff;
      e_q1_ff   <= d_q1_ff;
      e_q2_ff   <= e_q2_in;
      f_x_ff    <= e_x_ff;
      f_q2_ff   <= e_q2_ff;
      f_r2_ff   <= f_r2_in;
   end

   assign coord = coord_ff;

endmodule

/* src/lnei_step.sv */
`timescale 1ns / 1ps
// Pipeline that steps to the neighbour, re-encodes it and forms the result word.
module lnei_step (
   input  logic                clock,
   input  logic                reset,
   input  lnei_pkg::coord_type coord,
   input  lnei_pkg::cfg_type   cfg,
   output logic                rsp_strobe,
   output lnei_pkg::rsp_type   rsp_word
);

   lnei_pkg::coord_type h_ff, h_in;
   lnei_pkg::band_type  i_band_ff;
   logic [lnei_pkg::COORD_W-1:0] i_x_ff;
   logic [lnei_pkg::SQ_W-1:0]    i_ymul_ff, i_ymul_in;
   logic [lnei_pkg::CUBE_W-1:0]  i_zmul_ff, i_zmul_in;
   logic [lnei_pkg::CUBE_W-1:0]  i_wpart_ff, i_wpart_in;
   logic                         strobe_ff;
   lnei_pkg::rsp_type            rsp_ff, rsp_in;

   logic [2:0]                   paired;
   logic [lnei_pkg::SIDE_W-1:0]  up_sum;
   logic                         move;
   logic [lnei_pkg::VIDX_W-1:0]  nb;
   logic [lnei_pkg::VIDX_W-1:0]  base;

   always_comb begin
      paired      = lnei_pkg::paired_of(coord.band.dir);
      h_in.band   = coord.band;
      h_in.band.w = ~coord.band.w;
      h_in.crd    = coord.crd;
      up_sum      = '0;
      move        = 1'b0;
      for (int a = 0; a < 3; a++) begin
         move   = paired[a] ^ coord.band.neg ^ ~coord.band.w;
         up_sum = {1'b0, coord.crd[a]} + 1'b1;
         if (move) begin
            if (coord.band.w) begin
               h_in.crd[a] = (up_sum >= cfg.side) ? '0 : lnei_pkg::COORD_W'(up_sum);
            end else begin
               h_in.crd[a] = (coord.crd[a] == '0) ? lnei_pkg::COORD_W'(cfg.side - 1'b1)
                                                  : coord.crd[a] - 1'b1;
            end
         end
      end
   end

   always_comb begin
      i_ymul_in  = lnei_pkg::SQ_W'(h_ff.crd[1] * cfg.side);
      i_zmul_in  = lnei_pkg::CUBE_W'(h_ff.crd[2] * cfg.sq);
      i_wpart_in = h_ff.band.w ? cfg.cube : '0;
   end

   always_comb begin
      nb   = lnei_pkg::VIDX_W'(i_x_ff) + lnei_pkg::VIDX_W'(i_ymul_ff)
           + i_zmul_ff + i_wpart_ff;
      base = i_band_ff.neg ? nb : i_band_ff.vidx;
      if (i_band_ff.err) begin
         rsp_in.neighbour_index = '0;
         rsp_in.edge_number     = '0;
         rsp_in.index_error     = 1'b1;
      end else begin
         rsp_in.neighbour_index = nb;
         rsp_in.edge_number     = {base, i_band_ff.dir};
         rsp_in.index_error     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff      <= '0;
         i_band_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         h_ff      <= h_in;
         i_band_ff <= h_ff.band;
         strobe_ff <= i_band_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      i_x_ff     <= h_ff.crd[0];
      i_ymul_ff  <= i_ymul_in;
      i_zmul_ff  <= i_zmul_in;
      i_wpart_ff <= i_wpart_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

/* verif/tb_lattice_neighbour_edge_index.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the lattice neighbour and edge index generator.
module tb_lattice_neighbour_edge_index;

   localparam int PIPE_DEPTH  = 9;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SEGMENTS    = 8;
   localparam int SEG_WORDS   = 250;
   localparam logic [3:0][lnei_pkg::DIR_W-1:0] DIR_LIST =
      {lnei_pkg::DIR_XYZ, lnei_pkg::DIR_YZ, lnei_pkg::DIR_XZ, lnei_pkg::DIR_XY};

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic                          busy;
   lnei_pkg::req_type             req_word  = '0;
   logic                          rsp_strobe;
   lnei_pkg::rsp_type             rsp_word;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [lnei_pkg::SIDE_W-1:0]   csr_data  = '0;

   lnei_pkg::rsp_type             neighbour_q[$];
   logic [lnei_pkg::SIDE_W-1:0]   side_setting = lnei_pkg::RESET_SIDE;
   logic [lnei_pkg::SIDE_W-1:0]   stim_side    = lnei_pkg::RESET_SIDE;
   bit                            gaps_on      = 1'b1;
   int                            fail_count   = 0;
   int                            words_sent   = 0;
   int                            range_errors = 0;
   int                            side_writes  = 0;
   int                            cycle_count  = 0;

   lattice_neighbour_edge_index DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned side_in_use(input logic [lnei_pkg::SIDE_W-1:0] s);
      if (s == 0) return 1;
      if (s > lnei_pkg::MaxSide) return lnei_pkg::MaxSide;
      return s;
   endfunction

   function automatic lnei_pkg::rsp_type predict_neighbour(input lnei_pkg::req_type w,
                                                           input logic [lnei_pkg::SIDE_W-1:0] s);
      lnei_pkg::rsp_type r;
      int unsigned side, sq, cube, v, sub, nb, base;
      int unsigned crd [3];
      int          odd_axis;
      int          a;
      bit          moves;
      r = '0;
      side = side_in_use(s);
      sq = side * side;
      cube = sq * side;
      v = w.vertex_index;
      if (v >= 2 * cube) begin
         r.index_error = 1'b1;
         return r;
      end
      crd[0] = v % side;
      crd[1] = (v / side) % side;
      crd[2] = (v / sq) % side;
      sub = v / cube;
      case (w.direction)
         lnei_pkg::DIR_XY: odd_axis = 2;
         lnei_pkg::DIR_XZ: odd_axis = 1;
         lnei_pkg::DIR_YZ: odd_axis = 0;
         default: odd_axis = -1;
      endcase
      for (a = 0; a < 3; a++) begin
         moves = (a != odd_axis) ^ (sub == 0) ^ w.negative;
         if (moves) begin
            if (sub == 1) crd[a] = (crd[a] + 1 >= side) ? 0 : crd[a] + 1;
            else crd[a] = (crd[a] == 0) ? side - 1 : crd[a] - 1;
         end
      end
      nb = crd[0] + crd[1] * side + crd[2] * sq + (1 - sub) * cube;
      base = w.negative ? nb : v;
      r.neighbour_index = nb[lnei_pkg::VIDX_W-1:0];
      r.edge_number = lnei_pkg::EDGE_W'(4 * base + w.direction);
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      lnei_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            neighbour_q.insert(neighbour_q.size(), predict_neighbour(req_word, side_setting));
            words_sent++;
         end
         if (rsp_strobe) begin
            if (neighbour_q.size() == 0) begin
               $error("Result word arrived with no word pending.");
               fail_count++;
            end else begin
               want = neighbour_q.pop_front();
               if (want.index_error) range_errors++;
               if (rsp_word.neighbour_index !== want.neighbour_index) begin
                  $error("neighbour_index expected %0d got %0d",
                         want.neighbour_index, rsp_word.neighbour_index);
                  fail_count++;
               end
               if (rsp_word.edge_number !== want.edge_number) begin
                  $error("edge_number expected %0d got %0d",
                         want.edge_number, rsp_word.edge_number);
                  fail_count++;
               end
               if (rsp_word.index_error !== want.index_error) begin
                  $error("index_error expected %0d got %0d",
                         want.index_error, rsp_word.index_error);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            side_setting <= csr_data;
            side_writes++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [lnei_pkg::VIDX_W-1:0] vidx,
                            input logic [lnei_pkg::DIR_W-1:0] dir,
                            input logic neg);
      lnei_pkg::req_type w;
      w.vertex_index = vidx;
      w.direction = dir;
      w.negative = neg;
      if (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (neighbour_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_side(input logic [lnei_pkg::SIDE_W-1:0] s);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= s;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      stim_side = s;
   endtask

   function automatic logic [lnei_pkg::VIDX_W-1:0] pick_vertex();
      int unsigned lim;
      int unsigned mode;
      lim = 2 * side_in_use(stim_side) ** 3;
      mode = $urandom_range(99);
      if (mode < 80) return lnei_pkg::VIDX_W'($urandom_range(lim - 1));
      if (mode < 92) begin
         case ($urandom_range(3))
            0: return '0;
            1: return lnei_pkg::VIDX_W'(lim - 1);
            2: return lnei_pkg::VIDX_W'(lim);
            default: return lnei_pkg::VIDX_W'(lim + 1);
         endcase
      end
      return lnei_pkg::VIDX_W'($urandom());
   endfunction

   task automatic test_reset_side();
      int d;
      for (d = 0; d < 4; d++) begin
         send_word('0, DIR_LIST[d], 1'b0);
         send_word('0, DIR_LIST[d], 1'b1);
         send_word(lnei_pkg::VIDX_W'(127), DIR_LIST[d], 1'b0);
      end
      send_word(lnei_pkg::VIDX_W'(127), lnei_pkg::DIR_XYZ, 1'b1);
      send_word(lnei_pkg::VIDX_W'(64), lnei_pkg::DIR_XY, 1'b1);
      send_word(lnei_pkg::VIDX_W'(64), lnei_pkg::DIR_XYZ, 1'b0);
      send_word(lnei_pkg::VIDX_W'(63), lnei_pkg::DIR_XYZ, 1'b0);
      send_word(lnei_pkg::VIDX_W'(63), lnei_pkg::DIR_YZ, 1'b1);
      send_word(lnei_pkg::VIDX_W'(128), lnei_pkg::DIR_XZ, 1'b0);
      send_word('1, lnei_pkg::DIR_XYZ, 1'b1);
      drain_results();
   endtask

   task automatic test_side_sweep();
      logic [6:0][lnei_pkg::SIDE_W-1:0] sides;
      int unsigned lim;
      int k, d;
      sides = {7'd3, 7'd65, 7'd127, 7'd64, 7'd2, 7'd0, 7'd1};
      for (k = 0; k < 7; k++) begin
         write_side(sides[k]);
         lim = 2 * side_in_use(stim_side) ** 3;
         for (d = 0; d < 4; d++) begin
            send_word('0, DIR_LIST[d], d[0]);
            send_word(lnei_pkg::VIDX_W'(lim - 1), DIR_LIST[d], ~d[0]);
            send_word(lnei_pkg::VIDX_W'(lim), DIR_LIST[d], d[1]);
            send_word(lnei_pkg::VIDX_W'($urandom_range(lim - 1)), DIR_LIST[d],
                      1'($urandom()));
         end
      end
   endtask

   task automatic test_random_stream();
      int seg, n;
      logic [lnei_pkg::SIDE_W-1:0] s;
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 0) s = lnei_pkg::MAX_SIDE_V;
         else if (seg == SEGMENTS - 1) s = '1;
         else if ($urandom_range(7) == 0) s = lnei_pkg::SIDE_W'($urandom_range(127));
         else s = lnei_pkg::SIDE_W'($urandom_range(1, 12));
         write_side(s);
         gaps_on = (seg != 3);
         for (n = 0; n < SEG_WORDS; n++) begin
            if (seg == 5 && n == SEG_WORDS / 2) drain_results();
            send_word(pick_vertex(), lnei_pkg::DIR_W'($urandom_range(3)), 1'($urandom()));
         end
      end
      gaps_on = 1'b1;
      write_side(lnei_pkg::RESET_SIDE);
      drain_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_side();
      test_side_sweep();
      test_random_stream();
      $display("Checked %0d words over %0d side writes, %0d of them out of range.",
               words_sent, side_writes, range_errors);
      $display("Sides covered the zero, one, maximum and saturated settings.");
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
